// ----- design/ede_pkg.sv -----
// edit distance engine package: request actions, controller states, cell control group
// and payload widths. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ede_pkg;

  localparam int ACTION_BITS = 2;
  localparam int SYMBOL_IN_BITS = 8;
  localparam int DIST_BITS = 8;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 8'hFF;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_FIRST   = 2'd0,
    ACT_SECOND  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/ede_req_if.sv -----
// request channel of the edit distance engine: valid/ready plus action and symbol.
// depends on ede_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface ede_req_if;
  logic                                valid;
  logic                                ready;
  logic [ede_pkg::ACTION_BITS-1:0]     action;
  logic [ede_pkg::SYMBOL_IN_BITS-1:0]  symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

// ----- design/ede_res_if.sv -----
// result channel of the edit distance engine: valid/ready plus distance and overflow.
// depends on ede_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface ede_res_if;
  logic                           valid;
  logic                           ready;
  logic [ede_pkg::DIST_BITS-1:0]  distance;
  logic                           overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

// ----- design/ede_cell.sv -----
// one column cell of the edit distance chain: holds one symbol of the second string
// and its column cost, and passes first-string symbols rightward. depends on ede_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ede_cell #(
  parameter int SB    = 8,
  parameter int CW    = 8,
  parameter int INDEX = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ede_pkg::cell_ctl_t ctl,
  input  wire logic [SB-1:0]     load_sym,
  input  wire logic [CW-1:0]     second_len,
  input  wire logic [SB-1:0]     a_in,
  input  wire logic              v_in,
  input  wire logic [CW-1:0]     left_in,
  input  wire logic [CW-1:0]     diag_in,
  output logic [SB-1:0]          a_out,
  output logic                   v_out,
  output logic [CW-1:0]          left_out,
  output logic [CW-1:0]          diag_out
);

  logic [SB-1:0] sym;
  logic          used;
  logic [CW-1:0] cost;
  logic [CW-1:0] cost_next;
  logic [CW-1:0] m2;
  logic [CW-1:0] m3;

  always_comb begin
    m2 = (diag_in < left_in) ? diag_in : left_in;
    m3 = (m2 < cost) ? m2 : cost;
    if (!used) begin
      // past the end of the second string: carry the score through
      cost_next = left_in;
    end else if (a_in == sym) begin
      cost_next = diag_in;
    end else begin
      cost_next = m3 + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (ctl.clear) begin
        used <= 1'b0;
      end else if (ctl.load && (second_len == CW'(INDEX - 1))) begin
        used <= 1'b1;
      end
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && (second_len == CW'(INDEX - 1))) begin
      sym <= load_sym;
    end
    a_out <= a_in;
    if (ctl.init) begin
      cost <= used ? CW'(INDEX) : second_len;
    end else if (v_in) begin
      cost     <= cost_next;
      diag_out <= cost;
    end
  end

  assign left_out = cost;

endmodule

`default_nettype wire

// ----- design/edit_distance_engine_core.sv -----
// Levenshtein edit distance engine. Requests with action 0 or 1 append a symbol to the
// first or second string; the second string is held in a row of MAX_LEN cells, one
// symbol per cell, and the first string in a local memory. A compute request streams
// the first string through the cell row, one symbol per cycle, each cell updating its
// column cost as the symbol passes, and then lets the final score travel to the end of
// the row; no request is taken during a compute. Loads keep being taken while a result
// waits in the output register. Appends to a full string are dropped and flagged in the
// next result; both strings are emptied after every compute.
`timescale 1ns / 1ps
`default_nettype none

module edit_distance_engine_core #(
  parameter int MAX_LEN     = 128,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ede_req_if.sink    req,
  ede_res_if.source  res
);

  localparam int SB = SYMBOL_BITS;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = $clog2(MAX_LEN + 3);
  localparam int DB = ede_pkg::DIST_BITS;

  ede_pkg::state_t    state;
  ede_pkg::state_t    state_next;
  ede_pkg::cell_ctl_t ctl;

  logic          accept;
  logic          do_first;
  logic          do_second;
  logic          start;
  logic          issue;
  logic          drain_start;
  logic          finish;
  logic          first_full;
  logic          second_full;

  logic [CW-1:0] first_len;
  logic [CW-1:0] second_len;
  logic          dropped;
  logic [CW-1:0] row;
  logic [DW-1:0] drain_cnt;
  logic          feed_v;
  logic [CW-1:0] feed_row;
  logic [SB-1:0] mem_q;
  logic [SB-1:0] sym_in;
  logic [SB+ede_pkg::SYMBOL_IN_BITS-1:0] sym_wide;
  logic [CW+DB-1:0] dist_wide;

  logic [SB-1:0] first_mem [0:MAX_LEN-1];

  logic [SB-1:0] a_link    [0:MAX_LEN];
  logic          v_link    [0:MAX_LEN];
  logic [CW-1:0] left_link [0:MAX_LEN];
  logic [CW-1:0] diag_link [0:MAX_LEN];

  assign sym_wide    = {{SB{1'b0}}, req.symbol};
  assign sym_in      = sym_wide[SB-1:0];
  assign first_full  = (first_len == CW'(MAX_LEN));
  assign second_full = (second_len == CW'(MAX_LEN));
  assign dist_wide   = {{DB{1'b0}}, left_link[MAX_LEN]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ede_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    accept      = 1'b0;
    do_first    = 1'b0;
    do_second   = 1'b0;
    start       = 1'b0;
    issue       = 1'b0;
    drain_start = 1'b0;
    finish      = 1'b0;
    case (state)
      ede_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        accept    = req.valid;
        if (accept) begin
          case (ede_pkg::action_t'(req.action))
            ede_pkg::ACT_FIRST:   do_first  = 1'b1;
            ede_pkg::ACT_SECOND:  do_second = 1'b1;
            ede_pkg::ACT_COMPUTE: begin
              start      = 1'b1;
              state_next = ede_pkg::ST_FEED;
            end
            default: ;
          endcase
        end
      end
      ede_pkg::ST_FEED: begin
        if (row == first_len) begin
          drain_start = 1'b1;
          state_next  = ede_pkg::ST_DRAIN;
        end else begin
          issue = 1'b1;
        end
      end
      ede_pkg::ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ede_pkg::ST_DONE;
        end
      end
      ede_pkg::ST_DONE: begin
        if (!res.valid || res.ready) begin
          finish     = 1'b1;
          state_next = ede_pkg::ST_IDLE;
        end
      end
      default: state_next = ede_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      dropped    <= 1'b0;
      feed_v     <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      feed_v <= issue;
      if (finish) begin
        first_len  <= '0;
        second_len <= '0;
        dropped    <= 1'b0;
        res.valid  <= 1'b1;
      end else begin
        if (res.ready) begin
          res.valid <= 1'b0;
        end
        if (do_first) begin
          if (first_full) begin
            dropped <= 1'b1;
          end else begin
            first_len <= first_len + CW'(1);
          end
        end
        if (do_second) begin
          if (second_full) begin
            dropped <= 1'b1;
          end else begin
            second_len <= second_len + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row <= '0;
    end else if (issue) begin
      row <= row + CW'(1);
    end
    if (drain_start) begin
      drain_cnt <= DW'(MAX_LEN + 2);
    end else if (drain_cnt != '0) begin
      drain_cnt <= drain_cnt - DW'(1);
    end
    feed_row <= row + CW'(1);
    if (finish) begin
      res.distance <= (dist_wide > (CW + DB)'(ede_pkg::DIST_MAX)) ?
                      ede_pkg::DIST_MAX : dist_wide[DB-1:0];
      res.overflow <= dropped;
    end
  end

  // first string store
  always_ff @(posedge clk) begin
    if (do_first && !first_full) begin
      first_mem[first_len[AW-1:0]] <= sym_in;
    end
    if (issue) begin
      mem_q <= first_mem[row[AW-1:0]];
    end
  end

  assign ctl.load  = do_second && !second_full;
  assign ctl.init  = start;
  assign ctl.clear = finish;

  // column zero of the table
  assign a_link[0]    = mem_q;
  assign v_link[0]    = feed_v;
  assign left_link[0] = feed_row;
  assign diag_link[0] = feed_row - CW'(1);

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    ede_cell #(
      .SB    (SB),
      .CW    (CW),
      .INDEX (g + 1)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_sym   (sym_in),
      .second_len (second_len),
      .a_in       (a_link[g]),
      .v_in       (v_link[g]),
      .left_in    (left_link[g]),
      .diag_in    (diag_link[g]),
      .a_out      (a_link[g+1]),
      .v_out      (v_link[g+1]),
      .left_out   (left_link[g+1]),
      .diag_out   (diag_link[g+1])
    );
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ede_pkg::ST_DONE))
    else $error("result raised outside completion");

  a_feed_from_issue: assert property (@(posedge clk) disable iff (rst)
    feed_v |-> $past(state == ede_pkg::ST_FEED) && $past(row != first_len))
    else $error("row fed without a read");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    (first_len <= CW'(MAX_LEN)) && (second_len <= CW'(MAX_LEN)))
    else $error("string length beyond capacity");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ede_pkg::ST_FEED) |=> (state != ede_pkg::ST_IDLE) && !finish)
    else $error("compute cut short");

endmodule

`default_nettype wire
